// File: hdl/wsfhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame header parser package
// Phase type, event codes and the result word shared by the parser modules.
// ----------------------------------------------------------------------------
package wsfhp_pkg;

   // Where the parser stands inside the current frame.
   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_LEN     = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_MASK    = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   // Event codes carried in each result word.
   localparam logic [2:0] EV_HEADER  = 3'd0;
   localparam logic [2:0] EV_HDRDONE = 3'd1;
   localparam logic [2:0] EV_DATA    = 3'd2;
   localparam logic [2:0] EV_EMPTY   = 3'd3;
   localparam logic [2:0] EV_BADOP   = 3'd4;

   // Opcodes that the parser accepts.
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   // Seven-bit length codes that announce an extended length.
   localparam logic [6:0] LEN_EXT64 = 7'd127;
   localparam logic [6:0] LEN_EXT16 = 7'd126;

   // Byte counts of the extended length and mask key fields.
   localparam logic [3:0] EXT64_BYTES    = 4'd8;
   localparam logic [3:0] EXT16_BYTES    = 4'd2;
   localparam logic [3:0] KEY_FIELD_BYTES = 4'd4;

   // One result word.
   typedef struct packed {
      logic [2:0]  event_res;
      logic [3:0]  opcode;
      logic        final_fragment;
      logic [2:0]  reserved_flags;
      logic        is_masked;
      logic [31:0] mask_key;
      logic [63:0] frame_length;
      logic [7:0]  data_byte;
      logic [1:0]  mask_lane;
      logic        last;
   } rsp_type;

   function automatic logic opcode_known(input logic [3:0] op);
      opcode_known = (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY) ||
                     (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
   endfunction

endpackage

// File: hdl/wsfhp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame header parser step
// Holds the frame state and works out the result word for one received byte.
// The state advances only when the caller takes the result.
// ----------------------------------------------------------------------------
module wsfhp_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic [7:0]       rx_byte,
   input  logic [2:0]       rsv_enable,
   output wsfhp_pkg::rsp_type result
);
   import wsfhp_pkg::*;

   phase_type   phase_ff,     phase_in;
   logic [3:0]  bytes_left_ff, bytes_left_in;
   logic [63:0] length_ff,    length_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [31:0] mask_ff,      mask_in;
   logic [3:0]  opcode_ff,    opcode_in;
   logic        fin_ff,       fin_in;
   logic [2:0]  rsv_ff,       rsv_in;
   logic        masked_ff,    masked_in;

   logic [2:0]  event_word;
   logic        last_word;
   logic [3:0]  op_rx;
   logic [2:0]  rsv_rx;
   logic [6:0]  len7;
   logic [3:0]  bytes_dec;
   logic [63:0] remaining_dec;

   assign op_rx         = rx_byte[3:0];
   assign rsv_rx        = rx_byte[6:4] & rsv_enable;
   assign len7          = rx_byte[6:0];
   assign bytes_dec     = (bytes_left_ff != 4'd0) ? bytes_left_ff - 4'd1 : 4'd0;
   assign remaining_dec = (remaining_ff != 64'd0) ? remaining_ff - 64'd1 : 64'd0;

   // Next state of the frame walker and the event that the byte causes.
   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      length_in     = length_ff;
      remaining_in  = remaining_ff;
      mask_in       = mask_ff;
      opcode_in     = opcode_ff;
      fin_in        = fin_ff;
      rsv_in        = rsv_ff;
      masked_in     = masked_ff;
      event_word    = EV_HEADER;
      last_word     = 1'b0;
      case (phase_ff)
         PH_LEN: begin
            masked_in = rx_byte[7];
            if (len7 == LEN_EXT64) begin
               length_in     = 64'd0;
               bytes_left_in = EXT64_BYTES;
               phase_in      = PH_EXTLEN;
            end else if (len7 == LEN_EXT16) begin
               length_in     = 64'd0;
               bytes_left_in = EXT16_BYTES;
               phase_in      = PH_EXTLEN;
            end else begin
               length_in = {57'd0, len7};
               if (rx_byte[7]) begin
                  phase_in      = PH_MASK;
                  bytes_left_in = KEY_FIELD_BYTES;
               end else if (len7 == 7'd0) begin
                  phase_in   = PH_START;
                  last_word  = 1'b1;
                  event_word = EV_EMPTY;
               end else begin
                  remaining_in = {57'd0, len7};
                  phase_in     = PH_PAYLOAD;
                  event_word   = EV_HDRDONE;
               end
            end
         end
         PH_EXTLEN: begin
            length_in     = {length_ff[55:0], rx_byte};
            bytes_left_in = bytes_dec;
            if (bytes_dec == 4'd0) begin
               if (masked_ff) begin
                  phase_in      = PH_MASK;
                  bytes_left_in = KEY_FIELD_BYTES;
               end else if (length_in == 64'd0) begin
                  phase_in   = PH_START;
                  last_word  = 1'b1;
                  event_word = EV_EMPTY;
               end else begin
                  remaining_in = length_in;
                  phase_in     = PH_PAYLOAD;
                  event_word   = EV_HDRDONE;
               end
            end
         end
         PH_MASK: begin
            mask_in       = {mask_ff[23:0], rx_byte};
            bytes_left_in = bytes_dec;
            if (bytes_dec == 4'd0) begin
               if (length_ff == 64'd0) begin
                  phase_in   = PH_START;
                  last_word  = 1'b1;
                  event_word = EV_EMPTY;
               end else begin
                  remaining_in = length_ff;
                  phase_in     = PH_PAYLOAD;
                  event_word   = EV_HDRDONE;
               end
            end
         end
         PH_PAYLOAD: begin
            remaining_in = remaining_dec;
            event_word   = EV_DATA;
            if (remaining_dec == 64'd0) begin
               last_word = 1'b1;
               phase_in  = PH_START;
            end
         end
         default: begin
            // Frame start: an unknown opcode leaves all state as it was.
            phase_in = PH_START;
            if (!opcode_known(op_rx)) begin
               event_word = EV_BADOP;
            end else begin
               if (op_rx != OP_CONT) begin
                  opcode_in = op_rx;
                  rsv_in    = rsv_rx;
               end else begin
                  rsv_in = rsv_ff | rsv_rx;
               end
               fin_in    = rx_byte[7];
               masked_in = 1'b0;
               mask_in   = 32'd0;
               length_in = 64'd0;
               phase_in  = PH_LEN;
            end
         end
      endcase
   end

   // Result word, built from the state after this byte; the mask lane comes from the state before it.
   always_comb begin
      result.event_res      = event_word;
      result.opcode         = (event_word == EV_BADOP) ? op_rx : opcode_in;
      result.final_fragment = fin_in;
      result.reserved_flags = rsv_in;
      result.is_masked      = masked_in;
      result.mask_key       = mask_in;
      result.frame_length   = length_in;
      result.data_byte      = (event_word == EV_DATA) ? rx_byte : 8'd0;
      result.mask_lane      = (event_word == EV_DATA) ?
                              (length_ff[1:0] - remaining_ff[1:0]) : 2'd0;
      result.last           = last_word;
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         bytes_left_ff <= 4'd0;
         length_ff     <= 64'd0;
         remaining_ff  <= 64'd0;
         mask_ff       <= 32'd0;
         opcode_ff     <= 4'd0;
         fin_ff        <= 1'b0;
         rsv_ff        <= 3'd0;
         masked_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         length_ff     <= length_in;
         remaining_ff  <= remaining_in;
         mask_ff       <= mask_in;
         opcode_ff     <= opcode_in;
         fin_ff        <= fin_in;
         rsv_ff        <= rsv_in;
         masked_ff     <= masked_in;
      end
   end

   // Payload words only occur with a nonzero count.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remaining_ff != 64'd0))
      else $error("payload phase with zero remaining count");

   // A field count stays nonzero inside the length and mask key fields.
   assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_EXTLEN) || (phase_ff == PH_MASK)) |-> (bytes_left_ff != 4'd0))
      else $error("field byte count exhausted inside a field");

   // The remaining count never exceeds the frame length.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remaining_ff <= length_ff))
      else $error("remaining count above frame length");

endmodule

// File: hdl/websocket_frame_header_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame header parser
// Walks the frame header of a received byte stream, one byte per word,
// and returns one result word per byte: header events, payload bytes with
// their mask lane, and a last flag on the final byte of each frame.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock and returns one result word per byte.
// An accepted byte is held in an input register, one step of the frame walker
// runs on it, and the word lands in the result register, which drives the
// result ports. While a result waits to be taken, one more byte can be
// accepted into the input register; after that the input stalls until the
// result moves, so the only limit on rate is the result channel's stall.
// Write the reserved flag enables only while no word is in flight.
module websocket_frame_header_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [3:0]  rsp_opcode,
   output logic        rsp_final_fragment,
   output logic [2:0]  rsp_reserved_flags,
   output logic        rsp_is_masked,
   output logic [31:0] rsp_mask_key,
   output logic [63:0] rsp_frame_length,
   output logic [7:0]  rsp_data_byte,
   output logic [1:0]  rsp_mask_lane,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data
);
   import wsfhp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;
   rsp_type    step_result;
   logic [2:0] rsv_enable_ff;
   logic       out_open;
   logic       advance;
   logic       req_take;

   // Flow control between the input register and the result register.
   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      rsp_valid_in = out_open ? in_valid_ff : rsp_valid_ff;
   end

   // Reserved flag enable register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsv_enable_ff <= 3'd0;
      end else if (csr_wr_en) begin
         rsv_enable_ff <= csr_wr_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   wsfhp_step u_step (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .rx_byte    (in_byte_ff),
      .rsv_enable (rsv_enable_ff),
      .result     (step_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = rsp_ff.event_res;
   assign rsp_opcode         = rsp_ff.opcode;
   assign rsp_final_fragment = rsp_ff.final_fragment;
   assign rsp_reserved_flags = rsp_ff.reserved_flags;
   assign rsp_is_masked      = rsp_ff.is_masked;
   assign rsp_mask_key       = rsp_ff.mask_key;
   assign rsp_frame_length   = rsp_ff.frame_length;
   assign rsp_data_byte      = rsp_ff.data_byte;
   assign rsp_mask_lane      = rsp_ff.mask_lane;
   assign rsp_last           = rsp_ff.last;

   // Only payload words carry a data byte and a mask lane.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.event_res != EV_DATA)) |->
      ((rsp_ff.data_byte == 8'd0) && (rsp_ff.mask_lane == 2'd0)))
      else $error("data byte or lane set on a non-payload word");

   // The last flag closes a frame only on payload or empty frame words.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last) |->
      ((rsp_ff.event_res == EV_DATA) || (rsp_ff.event_res == EV_EMPTY)))
      else $error("last flag on a header word");

   // A byte held behind a stalled result is not dropped.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && rsp_stall) |=> (in_valid_ff && rsp_valid_ff))
      else $error("held word lost under stall");

endmodule

// File: tb/tb_websocket_frame_header_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame header parser testbench
// Streams bytes into the parser, first a short set of hand-built frames and
// then long runs of random frames with noise mixed in. The reserved flag
// enables are changed between runs. A scoreboard class predicts the result
// word of every accepted byte and compares each returned word field by field.
// ----------------------------------------------------------------------------
module tb_websocket_frame_header_parser_top;
   import wsfhp_pkg::*;

   localparam int CYCLE_LIMIT = 150000;

   // Predicts the parser's result words and checks the returned ones.
   class frame_event_scoreboard;
      logic [2:0]  enables;
      phase_type   phase;
      logic [3:0]  field_left;
      logic [63:0] length_reg;
      logic [63:0] payload_left;
      logic [31:0] key_reg;
      logic [3:0]  cur_opcode;
      logic        cur_fin;
      logic [2:0]  cur_reserved;
      logic        cur_masked;
      rsp_type     expected_events [$];
      int          errors;

      function new();
         enables      = '0;
         phase        = PH_START;
         field_left   = '0;
         length_reg   = '0;
         payload_left = '0;
         key_reg      = '0;
         cur_opcode   = '0;
         cur_fin      = 1'b0;
         cur_reserved = '0;
         cur_masked   = 1'b0;
         errors       = 0;
      endfunction

      // Builds a word from the frame state held at this point.
      function rsp_type form_word(logic [2:0] ev, logic [3:0] op, logic [7:0] data,
                                  logic [1:0] lane, logic lst);
         rsp_type w;
         w.event_res      = ev;
         w.opcode         = op;
         w.final_fragment = cur_fin;
         w.reserved_flags = cur_reserved;
         w.is_masked      = cur_masked;
         w.mask_key       = key_reg;
         w.frame_length   = length_reg;
         w.data_byte      = data;
         w.mask_lane      = lane;
         w.last           = lst;
         return w;
      endfunction

      // The header is complete: either an empty frame ends or payload follows.
      function void close_header(output logic [2:0] ev, output logic lst);
         if (length_reg == 64'd0) begin
            phase = PH_START;
            ev    = EV_EMPTY;
            lst   = 1'b1;
         end else begin
            payload_left = length_reg;
            phase        = PH_PAYLOAD;
            ev           = EV_HDRDONE;
            lst          = 1'b0;
         end
      endfunction

      // The length is complete: a mask key may still be due.
      function void close_length(output logic [2:0] ev, output logic lst);
         if (cur_masked) begin
            phase      = PH_MASK;
            field_left = KEY_FIELD_BYTES;
            ev         = EV_HEADER;
            lst        = 1'b0;
         end else begin
            close_header(ev, lst);
         end
      endfunction

      // Steps the frame walk by one accepted byte and queues its result word.
      function void note_byte(logic [7:0] b);
         logic [2:0]  ev;
         logic        lst;
         logic [3:0]  op;
         logic [2:0]  acc;
         logic [63:0] offset;
         ev  = EV_HEADER;
         lst = 1'b0;
         case (phase)
            PH_LEN: begin
               cur_masked = b[7];
               if (b[6:0] == LEN_EXT64) begin
                  length_reg = '0;
                  field_left = EXT64_BYTES;
                  phase      = PH_EXTLEN;
               end else if (b[6:0] == LEN_EXT16) begin
                  length_reg = '0;
                  field_left = EXT16_BYTES;
                  phase      = PH_EXTLEN;
               end else begin
                  length_reg = {57'd0, b[6:0]};
                  close_length(ev, lst);
               end
            end
            PH_EXTLEN: begin
               length_reg = {length_reg[55:0], b};
               if (field_left != 4'd0) field_left = field_left - 4'd1;
               if (field_left == 4'd0) close_length(ev, lst);
            end
            PH_MASK: begin
               key_reg = {key_reg[23:0], b};
               if (field_left != 4'd0) field_left = field_left - 4'd1;
               if (field_left == 4'd0) close_header(ev, lst);
            end
            PH_PAYLOAD: begin
               offset = length_reg - payload_left;
               if (payload_left != 64'd0) payload_left = payload_left - 64'd1;
               if (payload_left == 64'd0) begin
                  lst   = 1'b1;
                  phase = PH_START;
               end
               expected_events.push_back(form_word(EV_DATA, cur_opcode, b, offset[1:0], lst));
               return;
            end
            default: begin
               op    = b[3:0];
               acc   = b[6:4] & enables;
               phase = PH_START;
               // An unknown opcode leaves the frame state untouched.
               if (!(op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG}))
               begin
                  expected_events.push_back(form_word(EV_BADOP, op, 8'd0, 2'd0, 1'b0));
                  return;
               end
               // A continuation frame keeps the opcode and merges the flags.
               if (op != OP_CONT) begin
                  cur_opcode   = op;
                  cur_reserved = '0;
               end
               cur_reserved = cur_reserved | acc;
               cur_fin      = b[7];
               cur_masked   = 1'b0;
               key_reg      = '0;
               length_reg   = '0;
               phase        = PH_LEN;
            end
         endcase
         expected_events.push_back(form_word(ev, cur_opcode, 8'd0, 2'd0, lst));
      endfunction

      task report(string msg);
         errors++;
         $display("Mismatch: %s", msg);
      endtask

      task compare_field(string name, logic [63:0] got_v, logic [63:0] want_v);
         if (got_v !== want_v)
            report($sformatf("%s got %0h, predicted %0h", name, got_v, want_v));
      endtask

      // Compares one returned word with the oldest prediction.
      task check_word(rsp_type got);
         rsp_type want;
         if (expected_events.size() == 0) begin
            report($sformatf("word with no prediction, event %0d", got.event_res));
            return;
         end
         want = expected_events.pop_front();
         compare_field("event_res", 64'(got.event_res), 64'(want.event_res));
         compare_field("opcode", 64'(got.opcode), 64'(want.opcode));
         compare_field("final_fragment", 64'(got.final_fragment),
                       64'(want.final_fragment));
         compare_field("reserved_flags", 64'(got.reserved_flags),
                       64'(want.reserved_flags));
         compare_field("is_masked", 64'(got.is_masked), 64'(want.is_masked));
         compare_field("mask_key", 64'(got.mask_key), 64'(want.mask_key));
         compare_field("frame_length", got.frame_length, want.frame_length);
         compare_field("data_byte", 64'(got.data_byte), 64'(want.data_byte));
         compare_field("mask_lane", 64'(got.mask_lane), 64'(want.mask_lane));
         compare_field("last", 64'(got.last), 64'(want.last));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_event_res;
   logic [3:0]  rsp_opcode;
   logic        rsp_final_fragment;
   logic [2:0]  rsp_reserved_flags;
   logic        rsp_is_masked;
   logic [31:0] rsp_mask_key;
   logic [63:0] rsp_frame_length;
   logic [7:0]  rsp_data_byte;
   logic [1:0]  rsp_mask_lane;
   logic        rsp_last;
   logic        csr_wr_en;
   logic [2:0]  csr_wr_data;

   frame_event_scoreboard events_sb;
   logic                  steady_flow = 1'b0;
   int                    cycle_count = 0;

   websocket_frame_header_parser_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side: take words, check them, and stall at random.
   initial begin
      rsp_type got;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.event_res      = rsp_event_res;
            got.opcode         = rsp_opcode;
            got.final_fragment = rsp_final_fragment;
            got.reserved_flags = rsp_reserved_flags;
            got.is_masked      = rsp_is_masked;
            got.mask_key       = rsp_mask_key;
            got.frame_length   = rsp_frame_length;
            got.data_byte      = rsp_data_byte;
            got.mask_lane      = rsp_mask_lane;
            got.last           = rsp_last;
            events_sb.check_word(got);
         end
         rsp_stall <= !steady_flow && ($urandom_range(0, 99) < 17);
      end
   end

   // Sends one byte, with random idle cycles ahead of it, and notes it once taken.
   task automatic send_byte(input logic [7:0] b);
      while (!steady_flow && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do begin
         @(posedge clock);
      end while (req_stall);
      events_sb.note_byte(b);
   endtask

   // Stops sending and waits until every predicted word has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (events_sb.expected_events.size() != 0) @(posedge clock);
   endtask

   // Writes the reserved flag enables while nothing is in flight.
   task automatic set_enables(input logic [2:0] value);
      wait_for_results();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      events_sb.enables = value;
   endtask

   // Random frames, steered by the predicted phase so that lengths stay short.
   task automatic random_stream(input int count);
      logic [7:0] b;
      logic [3:0] op;
      logic [6:0] len;
      int         sent;
      int         pick;
      sent = 0;
      while (sent < count || events_sb.phase != PH_START) begin
         pick = $urandom_range(0, 99);
         case (events_sb.phase)
            PH_START: begin
               case ($urandom_range(0, 5))
                  0: op = OP_CONT;
                  1: op = OP_TEXT;
                  2: op = OP_BINARY;
                  3: op = OP_CLOSE;
                  4: op = OP_PING;
                  default: op = OP_PONG;
               endcase
               if (pick < 14) begin
                  do begin
                     op = 4'($urandom_range(0, 15));
                  end while (op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING,
                                        OP_PONG});
               end
               b = {1'($urandom), 3'($urandom), op};
               // Some pure noise at frame start.
               if (pick < 8) b = 8'($urandom);
            end
            PH_LEN: begin
               if (pick < 15) len = 7'd0;
               else if (pick < 60) len = 7'($urandom_range(1, 12));
               else if (pick < 76) len = 7'($urandom_range(13, 40));
               else if (pick < 84) len = LEN_EXT16;
               else if (pick < 92) len = LEN_EXT64;
               else len = 7'($urandom);
               b = {1'($urandom), len};
            end
            PH_EXTLEN: begin
               // Only the two low bytes of an extended length carry a value.
               if (events_sb.field_left == 4'd1)
                  b = (pick < 75) ? 8'($urandom_range(0, 15)) : 8'($urandom);
               else if (events_sb.field_left == 4'd2)
                  b = (pick < 6) ? 8'd1 : 8'd0;
               else
                  b = 8'd0;
            end
            default: begin
               b = 8'($urandom);
            end
         endcase
         send_byte(b);
         sent++;
      end
   endtask

   initial begin
      logic [7:0] opening_bytes [];
      events_sb   = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= 8'd0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 3'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Hand-built frames: empty text frame, unknown opcodes, masked binary
      // frame, continuation with a 16-bit length, masked empty ping, close, pong.
      opening_bytes = '{
         {1'b1, 3'b000, OP_TEXT}, 8'h00,
         {1'b0, 3'b000, 4'hF},
         {1'b1, 3'b111, 4'hB},
         {1'b0, 3'b111, OP_BINARY}, {1'b1, 7'd1}, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'hFF,
         {1'b1, 3'b100, OP_CONT}, {1'b0, LEN_EXT16}, 8'h00, 8'h01, 8'h00,
         {1'b1, 3'b010, OP_PING}, {1'b1, 7'd0}, 8'h01, 8'h02, 8'h03, 8'h04,
         {1'b1, 3'b000, OP_CLOSE}, 8'h00,
         {1'b1, 3'b001, OP_PONG}, 8'h00
      };
      set_enables(3'b101);
      foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

      set_enables(3'b111);
      random_stream(350);

      // A long stretch with no idling on either side.
      set_enables(3'b000);
      steady_flow = 1'b1;
      random_stream(300);
      wait_for_results();
      steady_flow = 1'b0;

      set_enables(3'b010);
      random_stream(300);

      set_enables(3'($urandom));
      random_stream(300);

      // A final frame with a huge 64-bit length, cut short by the end of the run.
      send_byte({1'b1, 3'($urandom), OP_BINARY});
      send_byte({1'b1, LEN_EXT64});
      send_byte(8'($urandom_range(128, 255)));
      repeat (7) send_byte(8'($urandom));
      repeat (10) send_byte(8'($urandom));

      wait_for_results();
      repeat (8) @(posedge clock);
      if (events_sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: websocket_frame_header_parser_top.f
hdl/wsfhp_pkg.sv
hdl/wsfhp_step.sv
hdl/websocket_frame_header_parser_top.sv
tb/tb_websocket_frame_header_parser_top.sv
